/* design/bir_pkg.sv */
// bilinear image resampler package: shared types and constants
// no dependencies

package bir_pkg;

   localparam int CHANNELS = 4;
   localparam int CHAN_BITS = 8;
   localparam int ACC_BITS = 27;
   localparam int SIDE_BITS = 11;
   localparam int TEXEL_BITS = CHANNELS * CHAN_BITS;
   localparam int INDEX_BITS = 16;
   localparam int STORE_TEXELS = 65536;
   localparam int MAX_SIDE = 1024;

   typedef enum logic [2:0] {
      CFG_SRC_W = 3'd0,
      CFG_SRC_H = 3'd1,
      CFG_TGT_W = 3'd2,
      CFG_TGT_H = 3'd3,
      CFG_X_STEP = 3'd4,
      CFG_Y_STEP = 3'd5
   } cfg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_READ = 3'd1,
      ST_HORIZ = 3'd2,
      ST_VERT = 3'd3,
      ST_OUT = 3'd4
   } state_type;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   typedef struct packed {
      logic [CHAN_BITS-1:0] a;
      logic [CHAN_BITS-1:0] b;
      logic [15:0] frac;
      logic bypass;
   } lane_ctl_type;

endpackage

/* design/bir_if.sv */
// handshake channel interface with generic payload
// depends on nothing

interface bir_if #(parameter int PAYLOAD_BITS = 8);
   logic valid;
   logic ready;
   logic [PAYLOAD_BITS-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/bilinear_image_resampler.sv */
// bilinear image resampler top level: texel memory, sequencer, four lerp lanes
// depends on bir_pkg, bir_if and bir_lane
//
// A load request writes one texel. An emit request reads the four neighbor texels
// from a single-port texel memory, one per cycle, waits for the last read to land
// in the texel registers, runs the four channel lanes over both rows and then once
// vertically, and registers the pixel; the single memory port is why the texels
// are read one at a time. The result sits in an output register, and the next
// request is taken once it has been handed over or in the same cycle it leaves.

module bilinear_image_resampler #(
   parameter int FRACTION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   bir_if.sink req,
   bir_if.source rsp,
   input  logic csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [bir_pkg::ACC_BITS-1:0] csr_write_data
);
   localparam int AW = $clog2(bir_pkg::STORE_TEXELS);
   localparam int CB = bir_pkg::CHAN_BITS;
   localparam int IB = bir_pkg::ACC_BITS - FRACTION_BITS;
   localparam int CNT = $clog2(bir_pkg::MAX_SIDE);
   localparam int SB = bir_pkg::SIDE_BITS;
   localparam int PB = SB + IB + 1;

   // req payload: op, index, r, g, b, a (msb first)
   logic op;
   logic [bir_pkg::INDEX_BITS-1:0] src_idx;
   logic [bir_pkg::TEXEL_BITS-1:0] in_texel;
   assign op = req.payload[bir_pkg::INDEX_BITS + bir_pkg::TEXEL_BITS];
   assign src_idx = req.payload[bir_pkg::TEXEL_BITS +: bir_pkg::INDEX_BITS];
   assign in_texel = {req.payload[0 +: CB], req.payload[CB +: CB],
                      req.payload[2*CB +: CB], req.payload[3*CB +: CB]};

   logic [SB-1:0] src_w_ff, src_h_ff, tgt_w_ff, tgt_h_ff;
   logic [bir_pkg::ACC_BITS-1:0] x_step_ff, y_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SB'(1);
         src_h_ff <= SB'(1);
         tgt_w_ff <= SB'(1);
         tgt_h_ff <= SB'(1);
         x_step_ff <= bir_pkg::ACC_BITS'(65536);
         y_step_ff <= bir_pkg::ACC_BITS'(65536);
      end else if (csr_write_enable) begin
         case (bir_pkg::cfg_index_type'(csr_index))
            bir_pkg::CFG_SRC_W: src_w_ff <= csr_write_data[SB-1:0];
            bir_pkg::CFG_SRC_H: src_h_ff <= csr_write_data[SB-1:0];
            bir_pkg::CFG_TGT_W: tgt_w_ff <= csr_write_data[SB-1:0];
            bir_pkg::CFG_TGT_H: tgt_h_ff <= csr_write_data[SB-1:0];
            bir_pkg::CFG_X_STEP: x_step_ff <= csr_write_data;
            bir_pkg::CFG_Y_STEP: y_step_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   function automatic logic [SB-1:0] side(input logic [SB-1:0] v);
      if (v == '0) return SB'(1);
      if (v > SB'(bir_pkg::MAX_SIDE)) return SB'(bir_pkg::MAX_SIDE);
      return v;
   endfunction

   logic [SB-1:0] sw, sh, tw, th;
   assign sw = side(src_w_ff);
   assign sh = side(src_h_ff);
   assign tw = side(tgt_w_ff);
   assign th = side(tgt_h_ff);

   logic [CNT-1:0] col_ff, row_ff;
   logic [bir_pkg::ACC_BITS-1:0] cacc_ff, racc_ff;
   bir_pkg::state_type state_ff, state_in;
   logic [1:0] tap_ff;
   logic [bir_pkg::TEXEL_BITS-1:0] tex_ff [4];
   logic [bir_pkg::TEXEL_BITS-1:0] rdata_ff;
   logic rd_pend_ff;
   logic [1:0] rd_tap_ff;
   logic [CB-1:0] h0_ff [4];
   logic [CB-1:0] out_ff [4];
   logic last_ff, rsp_valid_ff;

   // neighbor coordinates
   logic [IB-1:0] xi, yi;
   logic x_edge, y_edge;
   logic [SB-1:0] xa, xb, ya, yb;
   assign xi = cacc_ff[bir_pkg::ACC_BITS-1 -: IB];
   assign yi = racc_ff[bir_pkg::ACC_BITS-1 -: IB];
   assign x_edge = !((PB'(xi) + PB'(1)) < PB'(sw));
   assign y_edge = !((PB'(yi) + PB'(1)) < PB'(sh));
   assign xa = x_edge ? sw - SB'(1) : xi[SB-1:0];
   assign xb = x_edge ? sw - SB'(1) : xi[SB-1:0] + SB'(1);
   assign ya = y_edge ? sh - SB'(1) : yi[SB-1:0];
   assign yb = y_edge ? sh - SB'(1) : yi[SB-1:0] + SB'(1);

   logic [SB-1:0] rsel, csel;
   logic [2*SB:0] raddr_full;
   always_comb begin
      rsel = tap_ff[1] ? yb : ya;
      csel = tap_ff[0] ? xb : xa;
      raddr_full = (2*SB+1)'(rsel) * (2*SB+1)'(sw) + (2*SB+1)'(csel);
   end

   // texel memory
   logic [bir_pkg::TEXEL_BITS-1:0] mem [bir_pkg::STORE_TEXELS];
   logic accept, mem_we, mem_re;
   assign accept = req.valid && req.ready;
   assign mem_we = accept && op == bir_pkg::OP_LOAD;
   assign mem_re = state_ff == bir_pkg::ST_READ;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[src_idx[AW-1:0]] <= in_texel;
      end else if (mem_re) begin
         rdata_ff <= mem[raddr_full[AW-1:0]];
      end
   end

   // lanes
   bir_pkg::lane_ctl_type ctl [4];
   logic [CB-1:0] lane_q [4];
   logic lane_en, h_phase;
   assign lane_en = state_ff == bir_pkg::ST_HORIZ || state_ff == bir_pkg::ST_VERT;
   assign h_phase = state_ff == bir_pkg::ST_HORIZ;

   for (genvar c = 0; c < bir_pkg::CHANNELS; c++) begin : g_lane
      always_comb begin
         if (h_phase) begin
            ctl[c].a = tap_ff[0] ? tex_ff[2][c*CB +: CB] : tex_ff[0][c*CB +: CB];
            ctl[c].b = tap_ff[0] ? tex_ff[3][c*CB +: CB] : tex_ff[1][c*CB +: CB];
            ctl[c].frac = 16'(cacc_ff[FRACTION_BITS-1:0]);
            ctl[c].bypass = x_edge;
         end else begin
            ctl[c].a = h0_ff[c];
            ctl[c].b = lane_q[c];
            ctl[c].frac = 16'(racc_ff[FRACTION_BITS-1:0]);
            ctl[c].bypass = y_edge;
         end
      end
      bir_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane (
         .clock(clock), .enable(lane_en), .ctl(ctl[c]), .result(lane_q[c]));
   end

   logic last_col, last_frame;
   assign last_col = !((SB'(col_ff) + SB'(1)) < tw);
   assign last_frame = last_col && !((SB'(row_ff) + SB'(1)) < th);

   // sequencer: read taps 0..3, two horizontal passes, one vertical, then merge out
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bir_pkg::ST_IDLE: if (accept && op == bir_pkg::OP_EMIT) state_in = bir_pkg::ST_READ;
         bir_pkg::ST_READ: if (tap_ff == 2'd3) state_in = bir_pkg::ST_HORIZ;
         bir_pkg::ST_HORIZ: if (tap_ff == 2'd1) state_in = bir_pkg::ST_VERT;
         bir_pkg::ST_VERT: state_in = bir_pkg::ST_OUT;
         bir_pkg::ST_OUT: state_in = bir_pkg::ST_IDLE;
         default: state_in = bir_pkg::ST_IDLE;
      endcase
   end

   logic rd_wait;
   assign rd_wait = state_ff == bir_pkg::ST_HORIZ && tap_ff == 2'd0 && rd_pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bir_pkg::ST_IDLE;
         tap_ff <= '0;
         rd_pend_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
         cacc_ff <= '0;
         racc_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= mem_re;
         rd_tap_ff <= tap_ff;
         if (rd_pend_ff) tex_ff[rd_tap_ff] <= rdata_ff;
         if (rd_wait) begin
            state_ff <= state_ff;
         end else begin
            state_ff <= state_in;
            if (state_ff == bir_pkg::ST_READ || state_ff == bir_pkg::ST_HORIZ) begin
               tap_ff <= (state_in != state_ff) ? 2'd0 : tap_ff + 2'd1;
            end
         end
         if (state_ff == bir_pkg::ST_HORIZ && tap_ff == 2'd1 && !rd_wait) begin
            for (int c = 0; c < bir_pkg::CHANNELS; c++) h0_ff[c] <= lane_q[c];
         end
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == bir_pkg::ST_OUT) begin
            for (int c = 0; c < bir_pkg::CHANNELS; c++) out_ff[c] <= lane_q[c];
            last_ff <= last_frame;
            rsp_valid_ff <= 1'b1;
            if (!last_col) begin
               col_ff <= col_ff + CNT'(1);
               cacc_ff <= cacc_ff + x_step_ff;
            end else if (!last_frame) begin
               col_ff <= '0;
               cacc_ff <= '0;
               row_ff <= row_ff + CNT'(1);
               racc_ff <= racc_ff + y_step_ff;
            end else begin
               col_ff <= '0;
               row_ff <= '0;
               cacc_ff <= '0;
               racc_ff <= '0;
            end
         end
      end
   end

   assign req.ready = state_ff == bir_pkg::ST_IDLE && (!rsp_valid_ff || rsp.ready);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = {out_ff[0], out_ff[1], out_ff[2], out_ff[3], last_ff};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != bir_pkg::ST_IDLE |-> !req.ready) else $error("ready while busy");
   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == bir_pkg::ST_OUT |=> rsp.valid) else $error("result lost");
   a_read_then_horiz: assert property (@(posedge clock) disable iff (reset)
      state_ff == bir_pkg::ST_READ && tap_ff == 2'd3 |=> state_ff == bir_pkg::ST_HORIZ)
      else $error("bad read sequence");
endmodule

/* design/bir_lane.sv */
// one channel lerp lane: a + floor((b-a)*f/2^fb), registered result
// depends on bir_pkg

module bir_lane #(
   parameter int FRACTION_BITS = 16
) (
   input  logic clock,
   input  logic enable,
   input  bir_pkg::lane_ctl_type ctl,
   output logic [bir_pkg::CHAN_BITS-1:0] result
);
   localparam int PROD_BITS = bir_pkg::CHAN_BITS + FRACTION_BITS;
   logic [bir_pkg::CHAN_BITS-1:0] result_ff, result_in, diff;
   logic [PROD_BITS-1:0] prod;
   logic [PROD_BITS:0] prod_up;
   logic [FRACTION_BITS-1:0] f;
   logic up;

   always_comb begin
      f = ctl.frac[FRACTION_BITS-1:0];
      up = ctl.b >= ctl.a;
      diff = up ? ctl.b - ctl.a : ctl.a - ctl.b;
      prod = PROD_BITS'(diff) * PROD_BITS'(f);
      prod_up = {1'b0, prod} + {{(PROD_BITS-FRACTION_BITS+1){1'b0}}, {FRACTION_BITS{1'b1}}};
      if (ctl.bypass) begin
         result_in = ctl.a;
      end else if (up) begin
         result_in = ctl.a + prod[PROD_BITS-1 -: bir_pkg::CHAN_BITS];
      end else begin
         result_in = ctl.a - prod_up[FRACTION_BITS +: bir_pkg::CHAN_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;
endmodule
